FILE: src/cwa_pkg.sv
// Shared types and fixed constants for the centred window average unit.
// No dependencies.
package cwa_pkg;

	localparam int RADIUS_W = 5;
	localparam int SEEN_W   = 6;
	localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_EMIT
	} cwa_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cwa_div_stat_t;

endpackage

FILE: src/cwa_hist.sv
// Sample history memory: one write port, one registered read port.
// Depends on nothing.
module cwa_hist #(
	parameter int DATA_W = 16,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/cwa_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on cwa_pkg for the status struct.
module cwa_div #(
	parameter int DW = 22,
	parameter int VW = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DW-1:0]          dividend,
	input  logic [VW-1:0]          divisor,
	output logic [DW-1:0]          quotient,
	output cwa_pkg::cwa_div_stat_t stat
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    q_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    divisor_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      rem_sh;
	logic [VW+1:0]    diff;
	logic             qbit;

	assign rem_sh = {rem_q, q_q[DW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, divisor_q};
	assign qbit   = ~diff[VW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q       <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[VW-1:0] : rem_sh[VW-1:0];
			q_q   <= {q_q[DW-2:0], qbit};
		end
	end

	assign quotient  = q_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: src/centered_window_average_unit.sv
// Top level: centred moving average of radius k with a flush on the last sample.
// Depends on cwa_pkg, cwa_hist and cwa_div.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_data (radius)
//  in      | in        | in_valid/in_stall    | sample, last_sample
//  out     | out       | out_valid/out_stall  | average, last_result
//
// Full window: UPD, then SAMPLE_BITS+6 divider steps in DIV (22 at defaults), then EMIT.
// Incomplete window: UPD then EMIT; no result: UPD back to IDLE. Each flushed -1 is one more result in EMIT.
// The serial divider sets the rate; one transaction is worked at a time.
// Reset clears radius to 1 and empties the sequence; history needs no clearing.
// A stalled output holds the block; no input is taken until all results leave.
module centered_window_average_unit #(
	parameter int MAX_RADIUS  = 31,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cwa_pkg::RADIUS_W-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [SAMPLE_BITS-1:0]             sample,
	input  logic                               last_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [SAMPLE_BITS:0]        average,
	output logic                               last_result
);

	localparam int HIST_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int ADDR_W     = $clog2(HIST_DEPTH);
	localparam int K_W        = $clog2(MAX_RADIUS + 1);
	localparam int SPAN_W     = K_W + 1;
	localparam int SUM_W      = SAMPLE_BITS + 6;
	localparam int AVG_W      = SAMPLE_BITS + 1;
	localparam int CMP_W      = (K_W + 1 > cwa_pkg::SEEN_W) ? K_W + 1 : cwa_pkg::SEEN_W;

	cwa_pkg::cwa_state_t state_q, state_d;

	logic [cwa_pkg::RADIUS_W-1:0] radius_q;
	logic [ADDR_W-1:0]            wr_ptr_q;
	logic [SUM_W-1:0]             sum_q;
	logic [cwa_pkg::SEEN_W-1:0]   seen_q;
	logic [K_W-1:0]               flush_q;
	logic [SAMPLE_BITS-1:0]       sample_q;
	logic                         last_q;
	logic [cwa_pkg::SEEN_W-1:0]   seen_before_q;
	logic                         old_ok_q;
	logic [AVG_W-1:0]             average_q;
	logic                         last_result_q;

	logic [K_W-1:0]               k;
	logic [SPAN_W-1:0]            span;
	logic [CMP_W-1:0]             k_ext, two_k_ext, span_ext;
	logic [CMP_W-1:0]             seen_ext, seen_b_ext, seen_new_ext;
	logic [cwa_pkg::SEEN_W-1:0]   seen_new;
	logic [K_W-1:0]               lag;
	logic [SUM_W-1:0]             old_val, sum_next;
	logic                         has_main, full;
	logic                         accept, cfg_wr, take;
	logic                         div_start;
	logic [SAMPLE_BITS-1:0]       hist_rd_data;
	logic [SUM_W-1:0]             div_q;
	cwa_pkg::cwa_div_stat_t       div_stat;

	always_comb begin
		if (32'(radius_q) > MAX_RADIUS) begin
			k = K_W'(MAX_RADIUS);
		end else begin
			k = K_W'(radius_q);
		end
	end

	assign span         = {k, 1'b1};
	assign k_ext        = CMP_W'(k);
	assign two_k_ext    = CMP_W'({k, 1'b0});
	assign span_ext     = CMP_W'(span);
	assign seen_ext     = CMP_W'(seen_q);
	assign seen_b_ext   = CMP_W'(seen_before_q);
	assign seen_new     = (seen_before_q == cwa_pkg::SEEN_MAX) ? cwa_pkg::SEEN_MAX
	                      : seen_before_q + 1'b1;
	assign seen_new_ext = CMP_W'(seen_new);
	assign lag          = (seen_new_ext < k_ext) ? K_W'(seen_new) : k;
	assign has_main     = seen_b_ext >= k_ext;
	assign full         = seen_b_ext >= two_k_ext;
	assign old_val      = old_ok_q ? SUM_W'(hist_rd_data) : '0;
	assign sum_next     = sum_q + SUM_W'(sample_q) - old_val;

	assign accept = in_valid && !in_stall;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign take   = out_valid && !out_stall;

	cwa_hist #(
		.DATA_W (SAMPLE_BITS),
		.ADDR_W (ADDR_W)
	) u_hist (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (wr_ptr_q),
		.wr_data (sample),
		.rd_en   (accept),
		.rd_addr (wr_ptr_q - ADDR_W'(span)),
		.rd_data (hist_rd_data)
	);

	cwa_div #(
		.DW (SUM_W),
		.VW (SPAN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (span),
		.quotient (div_q),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a pending radius write takes the idle slot ahead of a sample
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		out_valid = 1'b0;
		div_start = 1'b0;
		case (state_q)
			cwa_pkg::ST_IDLE: begin
				in_stall  = cfg_valid;
				cfg_ready = 1'b1;
				if (in_valid && !cfg_valid) begin
					state_d = cwa_pkg::ST_UPD;
				end
			end
			cwa_pkg::ST_UPD: begin
				if (has_main && full) begin
					div_start = 1'b1;
					state_d   = cwa_pkg::ST_DIV;
				end else if (has_main || last_q) begin
					state_d = cwa_pkg::ST_EMIT;
				end else begin
					state_d = cwa_pkg::ST_IDLE;
				end
			end
			cwa_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = cwa_pkg::ST_EMIT;
				end
			end
			cwa_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall && flush_q == '0) begin
					state_d = cwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cwa_pkg::ST_IDLE;
			end
		endcase
	end

	// sequence state; cleared by a radius write or after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= cwa_pkg::RADIUS_W'(1);
			wr_ptr_q <= '0;
			sum_q    <= '0;
			seen_q   <= '0;
			flush_q  <= '0;
		end else begin
			if (cfg_wr) begin
				radius_q <= cfg_data;
				sum_q    <= '0;
				seen_q   <= '0;
			end
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (state_q == cwa_pkg::ST_UPD) begin
				sum_q  <= last_q ? '0 : sum_next;
				seen_q <= last_q ? '0 : seen_new;
				if (!last_q) begin
					flush_q <= '0;
				end else if (has_main) begin
					flush_q <= lag;
				end else begin
					flush_q <= lag - 1'b1;
				end
			end
			if (state_q == cwa_pkg::ST_EMIT && take && flush_q != '0) begin
				flush_q <= flush_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q      <= sample;
			last_q        <= last_sample;
			seen_before_q <= seen_q;
			old_ok_q      <= seen_ext >= span_ext;
		end
		if (state_q == cwa_pkg::ST_UPD && !(has_main && full)) begin
			average_q     <= '1;
			last_result_q <= last_q && (has_main ? (lag == '0) : (lag == K_W'(1)));
		end
		if (state_q == cwa_pkg::ST_DIV && div_stat.done) begin
			average_q     <= div_q[AVG_W-1:0];
			last_result_q <= last_q && (flush_q == '0);
		end
		if (state_q == cwa_pkg::ST_EMIT && take && flush_q != '0) begin
			average_q     <= '1;
			last_result_q <= flush_q == K_W'(1);
		end
	end

	assign average     = average_q;
	assign last_result = last_result_q;

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == cwa_pkg::ST_DIV))
		else $error("divider finished outside the divide phase");

	a_flush_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_q != '0) |-> (last_q && (state_q == cwa_pkg::ST_EMIT ||
		state_q == cwa_pkg::ST_DIV)))
		else $error("flush pending outside a final transaction");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_stat.busy)
		else $error("divider did not start");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for centered_window_average_unit: a directed table, partly with typed-in
// expected values, then random sequences checked against an in-bench model of the window average.
// Depends on cwa_pkg and the RTL under src.
module tb_top;

	localparam int MAX_RADIUS  = 31;
	localparam int SAMPLE_BITS = 16;
	localparam int HIST_DEPTH  = 2 * MAX_RADIUS + 1;
	localparam int SUM_W       = SAMPLE_BITS + 6;
	localparam int SETTLE      = 40;
	localparam int WATCHDOG    = 2000;
	localparam int RAND_ITEMS  = 250;
	localparam int CALM_AFTER  = 210;
	localparam logic signed [SAMPLE_BITS:0] NO_WINDOW = -1;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [SAMPLE_BITS-1:0]  data;
		logic                    last;
		bit                      typed;
		logic signed [SAMPLE_BITS:0] avg;
		logic                    lastr;
	} row_t;

	typedef struct {
		logic signed [SAMPLE_BITS:0] avg;
		logic                        last;
	} average_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [cwa_pkg::RADIUS_W-1:0]  cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [SAMPLE_BITS-1:0]        sample;
	logic                          last_sample;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [SAMPLE_BITS:0]   average;
	logic                          last_result;

	// window model
	logic [cwa_pkg::RADIUS_W-1:0]  radius_q;
	logic [SAMPLE_BITS-1:0]        hist [HIST_DEPTH];
	logic [SUM_W-1:0]              win_sum;
	int unsigned                   seen_cnt;

	average_t                      fresh_averages [$];
	average_t                      pending_averages [$];

	bit                            typed_on;
	logic signed [SAMPLE_BITS:0]   typed_avg;
	logic                          typed_last;

	bit                            in_fire;
	bit                            out_fire;
	bit                            cfg_fire;
	bit                            calm;
	int                            errors;
	int                            idle_cycles;
	int                            items_sent;

	row_t                          plan [$];

	centered_window_average_unit #(
		.MAX_RADIUS (MAX_RADIUS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.last_sample(last_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.average    (average),
		.last_result(last_result)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic void clear_window();
		int i;
		for (i = 0; i < HIST_DEPTH; i++)
			hist[i] = '0;
		win_sum  = '0;
		seen_cnt = 0;
	endfunction

	// advances the window by one sample, leaving its averages in fresh_averages
	function automatic void slide_window(input logic [SAMPLE_BITS-1:0] s, input logic l);
		int unsigned k;
		int unsigned span;
		int unsigned seen_prev;
		int unsigned lag;
		int unsigned p;
		int          i;
		average_t    r;
		fresh_averages.delete();
		k         = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
		span      = 2 * k + 1;
		seen_prev = seen_cnt;
		win_sum = win_sum + s - hist[span-1];
		for (i = HIST_DEPTH - 1; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0]  = s;
		seen_cnt = (seen_prev >= 63) ? 63 : seen_prev + 1;
		if (seen_prev >= k) begin
			if (seen_prev >= 2 * k)
				r.avg = (SAMPLE_BITS+1)'(win_sum / span);
			else
				r.avg = NO_WINDOW;
			r.last = 1'b0;
			fresh_averages.push_back(r);
		end
		lag = (seen_cnt < k) ? seen_cnt : k;
		if (l) begin
			for (p = 0; p < lag; p++) begin
				r.avg  = NO_WINDOW;
				r.last = 1'b0;
				fresh_averages.push_back(r);
			end
			fresh_averages[fresh_averages.size()-1].last = 1'b1;
			clear_window();
		end
	endfunction

	always @(posedge clk) begin
		average_t r;
		in_fire  = arst_n && in_valid && !in_stall;
		out_fire = arst_n && out_valid && !out_stall;
		cfg_fire = arst_n && cfg_valid && cfg_ready;
		if (out_fire) begin
			if (pending_averages.size() == 0) begin
				report_mismatch("unexpected average", average, 0);
			end else begin
				r = pending_averages.pop_front();
				if (average !== r.avg)
					report_mismatch("average", average, r.avg);
				if (last_result !== r.last)
					report_mismatch("last_result", last_result, r.last);
			end
		end
		if (cfg_fire) begin
			radius_q = cfg_data;
			clear_window();
		end
		if (in_fire) begin
			slide_window(sample, last_sample);
			if (typed_on) begin
				r.avg  = typed_avg;
				r.last = typed_last;
				pending_averages.push_back(r);
			end else begin
				foreach (fresh_averages[j])
					pending_averages.push_back(fresh_averages[j]);
			end
		end
		if (in_fire || out_fire || cfg_fire)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic l, input bit tv,
			input logic signed [SAMPLE_BITS:0] ta, input logic tl);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid    = 1'b1;
		sample      = s;
		last_sample = l;
		typed_on    = tv;
		typed_avg   = ta;
		typed_last  = tl;
		do @(negedge clk); while (!in_fire);
		items_sent++;
	endtask

	// only once every average has left and the unit has settled
	task automatic write_radius(input logic [cwa_pkg::RADIUS_W-1:0] r);
		in_valid = 1'b0;
		while (pending_averages.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = r;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       pick_sample = '0;
			1:       pick_sample = '1;
			default: pick_sample = SAMPLE_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int unsigned k;
		int unsigned len;
		int unsigned groups;
		int          n;
		int          g;
		bit          cut;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		sample      = '0;
		last_sample = 1'b0;
		typed_on    = 1'b0;
		typed_avg   = '0;
		typed_last  = 1'b0;
		calm        = 1'b0;
		errors      = 0;
		idle_cycles = 0;
		items_sent  = 0;
		radius_q    = 5'd1;
		clear_window();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// radius 1 out of reset: lone sample gives one flushed -1
		plan.push_back('{ROW_ITEM, 16'd100,   1'b1, 1'b1, NO_WINDOW, 1'b1});
		plan.push_back('{ROW_CFG,  16'd0,     1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd0,     1'b0, 1'b1, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd65535, 1'b0, 1'b1, 65535, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd12345, 1'b1, 1'b1, 12345, 1'b1});
		plan.push_back('{ROW_CFG,  16'd1,     1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd65535, 1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd65535, 1'b0, 1'b1, NO_WINDOW, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd65535, 1'b0, 1'b1, 65535, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd0,     1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd7,     1'b1, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_CFG,  16'd31,    1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd9,     1'b1, 1'b1, NO_WINDOW, 1'b1});
		// short sequence at full radius
		plan.push_back('{ROW_ITEM, 16'd1,     1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd2,     1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd3,     1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd4,     1'b1, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_CFG,  16'd2,     1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd500,   1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd600,   1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd700,   1'b0, 1'b0, 0, 1'b0});
		// radius change drops the open sequence
		plan.push_back('{ROW_CFG,  16'd3,     1'b0, 1'b0, 0, 1'b0});
		plan.push_back('{ROW_ITEM, 16'd0,     1'b1, 1'b1, NO_WINDOW, 1'b1});

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_radius(cwa_pkg::RADIUS_W'(plan[i].data));
			else
				send_sample(plan[i].data, plan[i].last, plan[i].typed, plan[i].avg,
					plan[i].lastr);
		end

		items_sent = 0;
		while (items_sent < RAND_ITEMS) begin
			case ($urandom_range(0, 5))
				0, 1, 2: k = $urandom_range(0, 3);
				3:       k = MAX_RADIUS;
				default: k = $urandom_range(0, MAX_RADIUS);
			endcase
			write_radius(cwa_pkg::RADIUS_W'(k));
			groups = $urandom_range(1, 3);
			for (g = 0; g < groups && items_sent < RAND_ITEMS; g++) begin
				if ($urandom_range(0, 6) == 0)
					len = $urandom_range(1, (k == 0) ? 1 : 2 * k);
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(64, 70);
				else
					len = 2 * k + 1 + $urandom_range(0, 10);
				cut = ($urandom_range(0, 9) == 0);
				for (n = 0; n < len; n++) begin
					calm = (items_sent >= CALM_AFTER);
					send_sample(pick_sample(), (n == len - 1) && !cut, 1'b0, 0, 1'b0);
				end
				if (cut)
					break;
			end
		end

		in_valid = 1'b0;
		while (pending_averages.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
